### hdl/dtns_pkg.sv
// shared types and constants for the decision tree node statistics block
// no dependencies
package dtns_pkg;

  localparam int unsigned AttrW  = 4;
  localparam int unsigned ValW   = 8;
  localparam int unsigned ClassW = 3;
  localparam int unsigned CntW   = 32;
  localparam int unsigned SumW   = 64;
  localparam int unsigned CfgW   = 4;
  localparam logic [CfgW-1:0] ClassIndexReset = 4'd15;

  localparam logic MODE_UPDATE    = 1'b0;
  localparam logic MODE_RECOMPUTE = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [AttrW-1:0]  attr_index;
    logic [ValW-1:0]   attr_value;
    logic [ClassW-1:0] class_label;
    logic              record_start;
  } in_beat_t;

  typedef struct packed {
    logic [CntW-1:0]   avc_count;
    logic [SumW-1:0]   value_sum;
    logic [SumW-1:0]   square_sum;
    logic [ClassW-1:0] majority_class;
    logic              majority_valid;
    logic [CntW-1:0]   majority_count;
    logic              mixed_classes;
    logic [CntW-1:0]   sample_total;
  } out_beat_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic clear_step;
    logic update;
    logic scan_step;
    logic emit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_done;
    logic scan_done;
    logic is_scan;
  } dp_sts_t;

endpackage

### hdl/dtns_if.sv
// valid/ready stream interface carrying one beat of type beat_t
// no dependencies
interface dtns_if #(parameter type beat_t = logic) ();
  logic  valid;
  logic  ready;
  beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/dtns_ctrl.sv
// controller: memory clear sweep, update and class scan sequencing
// depends on dtns_pkg
module dtns_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  dtns_pkg::dp_sts_t sts_i,
  output dtns_pkg::dp_cmd_t cmd_o
);
  import dtns_pkg::*;

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_UPDATE = 5'b00100,
    ST_SCAN   = 5'b01000,
    ST_OUT    = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   take;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign take        = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.load = take;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (take) state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (sts_i.is_scan) begin
          state_d = ST_SCAN;
        end else begin
          cmd_o.update = 1'b1;
          cmd_o.emit   = 1'b1;
          state_d      = ST_OUT;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_CLEAR;
    else state_q <= state_d;
  end
endmodule

### hdl/dtns_dp.sv
// datapath: counter memory, class counters, sums and majority registers
// depends on dtns_pkg
module dtns_dp #(
  parameter int unsigned NUM_ATTRS   = 16,
  parameter int unsigned VALUE_BITS  = 8,
  parameter int unsigned NUM_CLASSES = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [dtns_pkg::CfgW-1:0] class_index_i,
  input  dtns_pkg::in_beat_t     beat_i,
  input  dtns_pkg::dp_cmd_t      cmd_i,
  output dtns_pkg::dp_sts_t      sts_o,
  output dtns_pkg::out_beat_t    beat_o
);
  import dtns_pkg::*;

  localparam int unsigned NaW    = (NUM_ATTRS > 1) ? $clog2(NUM_ATTRS) : 1;
  localparam int unsigned NcW    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int unsigned Depth  = NUM_ATTRS * (2 ** VALUE_BITS) * NUM_CLASSES;
  localparam int unsigned AdrW   = $clog2(Depth);
  localparam int unsigned ScanW  = $clog2(NUM_CLASSES + 1);

  logic [CntW-1:0] avc_mem [Depth];
  logic [CntW-1:0] cls_q [NUM_CLASSES];
  logic [SumW-1:0] vsum_q [NUM_ATTRS];
  logic [SumW-1:0] ssum_q [NUM_ATTRS];
  logic [CntW-1:0] rec_q, best_cnt_q;
  logic [ClassW-1:0] best_cls_q;
  logic best_vld_q, mixed_q;
  logic [AdrW-1:0] clr_q;
  logic [ScanW-1:0] scan_q;
  in_beat_t b_q;
  logic [CntW-1:0] rd_q;
  out_beat_t o_q;

  logic attr_ok, cls_ok, in_sum;
  logic [NaW-1:0] ai;
  logic [NcW-1:0] ci;
  logic [VALUE_BITS-1:0] vv;
  logic [VALUE_BITS-1:0] bv;
  logic [2*VALUE_BITS-1:0] bsq;
  logic [AdrW-1:0] adr_in;
  logic [CntW-1:0] avc_new;
  logic [SumW-1:0] v64, sq64, vs_new, ss_new, vs_cur, ss_cur;
  logic [SumW:0] vs_add, ss_add;
  logic [CntW-1:0] sn;
  logic [NcW-1:0] si;

  assign attr_ok = {28'd0, b_q.attr_index} < NUM_ATTRS;
  assign cls_ok  = {29'd0, b_q.class_label} < NUM_CLASSES;
  assign ai      = NaW'(b_q.attr_index);
  assign ci      = NcW'(b_q.class_label);
  assign vv      = VALUE_BITS'(beat_i.attr_value);
  assign adr_in  = AdrW'(({32'd0, beat_i.attr_index} * (2 ** VALUE_BITS) + 64'(vv))
                   * NUM_CLASSES + 64'(beat_i.class_label));
  assign in_sum  = {1'b0, b_q.attr_index} <= {1'b0, class_index_i};
  assign bv      = VALUE_BITS'(b_q.attr_value);
  assign bsq     = {VALUE_BITS'(0), bv} * {VALUE_BITS'(0), bv};
  assign v64     = SumW'(bv);
  assign sq64    = SumW'(bsq);
  assign vs_cur  = attr_ok ? vsum_q[ai] : '0;
  assign ss_cur  = attr_ok ? ssum_q[ai] : '0;
  assign vs_add  = {1'b0, vs_cur} + {1'b0, v64};
  assign ss_add  = {1'b0, ss_cur} + {1'b0, sq64};
  assign vs_new  = (attr_ok && in_sum) ? (vs_add[SumW] ? '1 : vs_add[SumW-1:0]) : vs_cur;
  assign ss_new  = (attr_ok && in_sum) ? (ss_add[SumW] ? '1 : ss_add[SumW-1:0]) : ss_cur;
  assign avc_new = (&rd_q) ? rd_q : rd_q + 1'b1;
  assign si      = NcW'(scan_q);
  assign sn      = cls_q[si];

  assign sts_o.clear_done = (clr_q == AdrW'(Depth - 1));
  assign sts_o.scan_done  = (scan_q == ScanW'(NUM_CLASSES - 1));
  assign sts_o.is_scan    = (b_q.mode == MODE_RECOMPUTE);
  assign beat_o = o_q;

  // counter memory, one port pair, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_step) avc_mem[clr_q] <= '0;
    else if (cmd_i.update && attr_ok && cls_ok)
      avc_mem[AdrW'((({32'd0, b_q.attr_index} * (2 ** VALUE_BITS)
        + 64'(VALUE_BITS'(b_q.attr_value))) * NUM_CLASSES) + 64'(b_q.class_label))] <= avc_new;
    rd_q <= avc_mem[adr_in];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) b_q <= beat_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
      scan_q <= '0;
      rec_q <= '0;
      best_cnt_q <= '0;
      best_cls_q <= '0;
      best_vld_q <= 1'b0;
      mixed_q <= 1'b0;
      o_q <= '0;
      for (int i = 0; i < NUM_CLASSES; i++) cls_q[i] <= '0;
      for (int i = 0; i < NUM_ATTRS; i++) begin
        vsum_q[i] <= '0;
        ssum_q[i] <= '0;
      end
    end else begin
      if (cmd_i.clear_step) clr_q <= clr_q + 1'b1;
      if (cmd_i.update) begin
        logic [CntW-1:0] rec_n;
        logic mix_n;
        rec_n = rec_q;
        mix_n = mixed_q;
        if (b_q.record_start) begin
          rec_n = (&rec_q) ? rec_q : rec_q + 1'b1;
          if (cls_ok && !(&cls_q[ci])) cls_q[ci] <= cls_q[ci] + 1'b1;
          if (!best_vld_q || best_cls_q != b_q.class_label) mix_n = 1'b1;
        end
        rec_q <= rec_n;
        mixed_q <= mix_n;
        if (attr_ok) begin
          vsum_q[ai] <= vs_new;
          ssum_q[ai] <= ss_new;
        end
        o_q.avc_count <= (attr_ok && cls_ok) ? avc_new : '0;
        o_q.value_sum <= vs_new;
        o_q.square_sum <= ss_new;
        o_q.majority_class <= best_cls_q;
        o_q.majority_valid <= best_vld_q;
        o_q.majority_count <= best_cnt_q;
        o_q.mixed_classes <= mix_n;
        o_q.sample_total <= rec_n;
      end
      if (cmd_i.scan_step) begin
        logic take_c;
        take_c = (sn != '0) && (!best_vld_q || sn > best_cnt_q);
        if (take_c) begin
          best_cls_q <= ClassW'(scan_q);
          best_cnt_q <= sn;
          best_vld_q <= 1'b1;
        end
        scan_q <= sts_o.scan_done ? '0 : scan_q + 1'b1;
        if (sts_o.scan_done) begin
          o_q.avc_count <= '0;
          o_q.value_sum <= vs_cur;
          o_q.square_sum <= ss_cur;
          o_q.majority_class <= take_c ? ClassW'(scan_q) : best_cls_q;
          o_q.majority_valid <= take_c | best_vld_q;
          o_q.majority_count <= take_c ? sn : best_cnt_q;
          o_q.mixed_classes <= mixed_q;
          o_q.sample_total <= rec_q;
        end
      end
    end
  end
endmodule

### hdl/decision_tree_node_statistics.sv
// decision tree node statistics, top level
// depends on dtns_pkg, dtns_if, dtns_ctrl, dtns_dp
// update beat: accept and memory read, then write back and result register
// recompute beat: scans the class counters, one class counter per cycle
// after reset the counter memory is swept clear, one word per cycle, all
// NUM_ATTRS*2^VALUE_BITS*NUM_CLASSES words, input not ready meanwhile
module decision_tree_node_statistics #(
  parameter int unsigned NUM_ATTRS   = 16,
  parameter int unsigned VALUE_BITS  = 8,
  parameter int unsigned NUM_CLASSES = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [dtns_pkg::CfgW-1:0] cfg_wdata_i,
  dtns_if.sink                      in_if,
  dtns_if.source                    out_if
);
  import dtns_pkg::*;

  logic [CfgW-1:0] class_index_q;
  dp_cmd_t cmd;
  dp_sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) class_index_q <= ClassIndexReset;
    else if (cfg_we_i) class_index_q <= cfg_wdata_i;
  end

  dtns_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .sts_i(sts), .cmd_o(cmd)
  );

  dtns_dp #(.NUM_ATTRS(NUM_ATTRS), .VALUE_BITS(VALUE_BITS), .NUM_CLASSES(NUM_CLASSES)) u_dp (
    .clk_i, .rst_ni,
    .class_index_i(class_index_q),
    .beat_i(in_if.data), .cmd_i(cmd), .sts_o(sts), .beat_o(out_if.data)
  );
endmodule

### hdl/dtns_chk.sv
// port level checks for decision_tree_node_statistics
// bound to the top level
module dtns_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic mixed,
  input logic maj_valid
);
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready && out_valid)) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_done_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready |=> in_ready) else $error("not ready after result");
  a_mixed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && mixed |=> ##2 !out_valid || mixed)
    else $error("mixed flag cleared");
  a_maj_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && maj_valid |=> !out_valid || maj_valid)
    else $error("majority valid cleared");
endmodule

bind decision_tree_node_statistics dtns_chk u_chk (
  .clk_i, .rst_ni,
  .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready),
  .mixed(out_if.data.mixed_classes), .maj_valid(out_if.data.majority_valid)
);

### sim/decision_tree_node_statistics_tb.sv
// testbench for decision_tree_node_statistics: directed table then random record streams
// predicts every result beat with a local model of the leaf statistics and compares
// depends on dtns_pkg, dtns_if and the block's rtl
module decision_tree_node_statistics_tb;
  import dtns_pkg::*;

  localparam int unsigned NumAttrs   = 16;
  localparam int unsigned NumClasses = 8;
  localparam int unsigned AvcDepth   = NumAttrs * 256 * NumClasses;
  localparam logic [CntW-1:0] CntMax = '1;
  localparam logic [SumW-1:0] SumMax = '1;

  typedef struct {
    in_beat_t  beat;
    logic      check;
    out_beat_t want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgW-1:0] cfg_wdata_i = '0;

  dtns_if #(.beat_t(in_beat_t))  in_if ();
  dtns_if #(.beat_t(out_beat_t)) out_if ();

  decision_tree_node_statistics dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_if(in_if.sink), .out_if(out_if.source)
  );

  always #6 clk_i = ~clk_i;

  // leaf statistics kept by the testbench
  logic [CntW-1:0] avc_cnt [AvcDepth];
  logic [CntW-1:0] class_cnt [NumClasses];
  logic [SumW-1:0] val_sum [NumAttrs];
  logic [SumW-1:0] sq_sum [NumAttrs];
  logic [CntW-1:0] records;
  logic [ClassW-1:0] top_class;
  logic top_valid;
  logic [CntW-1:0] top_count;
  logic mixed;
  logic [CfgW-1:0] cls_idx;

  out_beat_t pending_stats [$];
  int errors = 0;
  bit in_done = 0;

  function automatic logic [CntW-1:0] bump(logic [CntW-1:0] x);
    return (x == CntMax) ? x : x + 1'b1;
  endfunction

  function automatic logic [SumW-1:0] add_sat(logic [SumW-1:0] a, logic [SumW-1:0] b);
    logic [SumW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SumW] ? SumMax : s[SumW-1:0];
  endfunction

  function automatic out_beat_t leaf_update(in_beat_t b);
    out_beat_t o;
    int idx;
    o = '0;
    if (b.mode == MODE_UPDATE) begin
      if (b.record_start) begin
        records = bump(records);
        class_cnt[b.class_label] = bump(class_cnt[b.class_label]);
        if (!top_valid || top_class != b.class_label) mixed = 1'b1;
      end
      if (b.attr_index <= cls_idx) begin
        val_sum[b.attr_index] = add_sat(val_sum[b.attr_index], SumW'(b.attr_value));
        sq_sum[b.attr_index] = add_sat(sq_sum[b.attr_index],
                                       SumW'(b.attr_value) * SumW'(b.attr_value));
      end
      idx = (int'(b.attr_index) * 256 + int'(b.attr_value)) * NumClasses + b.class_label;
      avc_cnt[idx] = bump(avc_cnt[idx]);
      o.avc_count = avc_cnt[idx];
    end else begin
      for (int c = 0; c < NumClasses; c++) begin
        if (class_cnt[c] != 0 && (!top_valid || class_cnt[c] > top_count)) begin
          top_class = ClassW'(c);
          top_count = class_cnt[c];
          top_valid = 1'b1;
        end
      end
    end
    o.value_sum = val_sum[b.attr_index];
    o.square_sum = sq_sum[b.attr_index];
    o.majority_class = top_class;
    o.majority_valid = top_valid;
    o.majority_count = top_count;
    o.mixed_classes = mixed;
    o.sample_total = records;
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [SumW-1:0] got, logic [SumW-1:0] want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // valid stays high after the beat; a gap or a drain drops it
  task automatic send_beat(in_beat_t b, logic check = 1'b0, out_beat_t want = '0);
    out_beat_t p;
    int gap;
    gap = $urandom_range(0, 12);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= b;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    p = leaf_update(b);
    if (check && p != want)
      report_mismatch("table row vs predictor", SumW'(p.sample_total), SumW'(want.sample_total));
    pending_stats.push_back(p);
  endtask

  task automatic drain(int extra = 0);
    in_if.valid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_class_index(logic [CfgW-1:0] v);
    drain(20);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cls_idx = v;
  endtask

  function automatic in_beat_t mk(int m, int a, int v, int c, int s);
    in_beat_t b;
    b.mode = 1'(m);
    b.attr_index = AttrW'(a);
    b.attr_value = ValW'(v);
    b.class_label = ClassW'(c);
    b.record_start = 1'(s);
    return b;
  endfunction

  // result side: random stalls, compare against oldest prediction
  initial begin
    out_beat_t w, g;
    int gap;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_if.valid) @(posedge clk_i);
      g = out_if.data;
      if (pending_stats.size() == 0) begin
        report_mismatch("beat with nothing expected", '0, '0);
      end else begin
        w = pending_stats.pop_front();
        if (g.avc_count !== w.avc_count)
          report_mismatch("avc_count", SumW'(g.avc_count), SumW'(w.avc_count));
        if (g.value_sum !== w.value_sum) report_mismatch("value_sum", g.value_sum, w.value_sum);
        if (g.square_sum !== w.square_sum)
          report_mismatch("square_sum", g.square_sum, w.square_sum);
        if (g.majority_class !== w.majority_class)
          report_mismatch("majority_class", SumW'(g.majority_class), SumW'(w.majority_class));
        if (g.majority_valid !== w.majority_valid)
          report_mismatch("majority_valid", SumW'(g.majority_valid), SumW'(w.majority_valid));
        if (g.majority_count !== w.majority_count)
          report_mismatch("majority_count", SumW'(g.majority_count), SumW'(w.majority_count));
        if (g.mixed_classes !== w.mixed_classes)
          report_mismatch("mixed_classes", SumW'(g.mixed_classes), SumW'(w.mixed_classes));
        if (g.sample_total !== w.sample_total)
          report_mismatch("sample_total", SumW'(g.sample_total), SumW'(w.sample_total));
      end
    end
  end

  initial begin
    stim_row_t rows [$];
    stim_row_t r;
    out_beat_t z;
    int n_attr, cls;
    in_valid_init();
    foreach (avc_cnt[i]) avc_cnt[i] = '0;
    foreach (class_cnt[i]) class_cnt[i] = '0;
    foreach (val_sum[i]) begin
      val_sum[i] = '0;
      sq_sum[i] = '0;
    end
    records = '0; top_class = '0; top_valid = 1'b0; top_count = '0; mixed = 1'b0;
    cls_idx = ClassIndexReset;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table: known answers where obvious
    z = '0;
    r.check = 1'b1; r.beat = mk(MODE_RECOMPUTE, 0, 0, 0, 0); r.want = z; rows.push_back(r);
    r.beat = mk(MODE_UPDATE, 0, 0, 0, 1);
    r.want = z; r.want.avc_count = 1; r.want.mixed_classes = 1; r.want.sample_total = 1;
    rows.push_back(r);
    r.beat = mk(MODE_UPDATE, 15, 255, 7, 0);
    r.want.value_sum = 255; r.want.square_sum = 65025; rows.push_back(r);
    r.check = 1'b0;
    r.beat = mk(MODE_UPDATE, 15, 255, 7, 1); rows.push_back(r);
    r.beat = mk(MODE_UPDATE, 3, 128, 7, 0); rows.push_back(r);
    r.beat = mk(MODE_RECOMPUTE, 15, 0, 0, 0); rows.push_back(r);
    r.beat = mk(MODE_UPDATE, 1, 1, 7, 1); rows.push_back(r);
    r.beat = mk(MODE_UPDATE, 2, 85, 2, 1); rows.push_back(r);
    r.beat = mk(MODE_UPDATE, 2, 170, 2, 1); rows.push_back(r);
    r.beat = mk(MODE_RECOMPUTE, 2, 9, 5, 1); rows.push_back(r);
    r.beat = mk(MODE_UPDATE, 0, 0, 0, 1); rows.push_back(r);
    r.beat = mk(MODE_RECOMPUTE, 0, 0, 0, 0); rows.push_back(r);
    foreach (rows[i]) send_beat(rows[i].beat, rows[i].check, rows[i].want);

    write_class_index(4'd1);
    send_beat(mk(MODE_UPDATE, 1, 200, 3, 1));
    send_beat(mk(MODE_UPDATE, 2, 200, 3, 0));
    send_beat(mk(MODE_UPDATE, 15, 200, 3, 0));

    // random records, class index changed between phases
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: write_class_index(4'd15);
        2: write_class_index(CfgW'($urandom_range(1, 15)));
        3: write_class_index(4'd1);
        4: write_class_index(CfgW'($urandom_range(1, 15)));
        5: write_class_index(4'd15);
        default: ;
      endcase
      for (int k = 0; k < 270; ) begin
        if ($urandom_range(0, 9) == 0) begin
          send_beat(mk($urandom_range(0, 1), $urandom_range(0, 15), $urandom_range(0, 255),
                       $urandom_range(0, 7), $urandom_range(0, 1)));
          k++;
        end else begin
          n_attr = $urandom_range(1, 16);
          cls = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 1) : $urandom_range(0, 7);
          for (int a = 0; a < n_attr; a++) begin
            send_beat(mk(MODE_UPDATE, a, $urandom_range(0, 255), cls, int'(a == 0)));
            k++;
          end
          if ($urandom_range(0, 3) == 0) begin
            send_beat(mk(MODE_RECOMPUTE, $urandom_range(0, 15), 0, 0, 0));
            k++;
          end
        end
      end
      if (ph == 2) drain();
    end

    drain(30);
    in_done = 1;
  end

  task automatic in_valid_init();
    in_if.valid = 1'b0;
    in_if.data = '0;
  endtask

  initial begin
    wait (in_done);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
